### hw/rtl/wsd_pkg.sv
// Shared types and codes for the work-stealing deque.
// Holds the request kinds, result status codes and the handle type.
// No dependencies.
`default_nettype none

package wsd_pkg;

  localparam int HANDLE_W = 32;
  localparam int LIMIT_W  = 7;
  localparam int FREE_W   = 17;

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [LIMIT_W-1:0]  limit_t;
  typedef logic [FREE_W-1:0]   free_t;

  // Largest number of handles one batch request may return.
  localparam limit_t MAX_BATCH = 7'd64;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_HALF  = 2'd2,
    KIND_STEAL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/wsd_ring.sv
// Task ring storage: one write port and one read port, read data registered.
// Depends on wsd_pkg for the handle type.
`default_nettype none

module wsd_ring #(
  parameter int AW = 6
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire [AW-1:0]         wr_addr,
  input  wsd_pkg::handle_t     wr_data,
  input  wire                  rd_en,
  input  wire [AW-1:0]         rd_addr,
  output wsd_pkg::handle_t     rd_data
);
  import wsd_pkg::*;

  handle_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/work_stealing_deque.sv
// Work-stealing task deque over a ring memory with a registered read port. Push,
// refused push, empty take and zero-limit take answer in the cycle after
// acceptance; pop and batch takes load theirs from the ring's read data, and a
// batch then gives one handle per cycle, set by the ring's single read port, while
// the result side keeps up. A new request is taken once the previous one has
// issued its last result. Reset (synchronous, rst high) empties the deque at once.
`default_nettype none

module work_stealing_deque #(
  parameter int DEPTH = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  // Request channel.
  input  wire                 req_valid,
  output logic                req_ready,
  input  wire [1:0]           kind,
  input  wsd_pkg::handle_t    task_handle,
  input  wsd_pkg::limit_t     batch_limit,
  // Result channel.
  output logic                rsp_valid,
  input  wire                 rsp_ready,
  output wsd_pkg::handle_t    out_handle,
  output logic                handle_valid,
  output logic                last,
  output logic [1:0]          status,
  output wsd_pkg::free_t      free_slots
);
  import wsd_pkg::*;

  // Ring address width, and index width: indexes count modulo twice the depth,
  // so the top bit of the occupancy tells a full ring from an empty one.
  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_POP   = 3'b010,
    S_BATCH = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [PW-1:0] bottom, bottom_next;
  logic [PW-1:0] top, top_next;
  limit_t        remain, remain_next;

  // Ring port controls.
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  handle_t       rd_data;

  // Result register load.
  logic          slot_free;
  logic          load;
  handle_t       ld_handle;
  logic          ld_valid;
  logic          ld_last;
  status_t       ld_status;
  free_t         ld_free;

  // Occupancy and the derived batch size.
  logic [PW-1:0] occ;
  logic [PW-1:0] bot_dec;
  logic          full;
  logic          empty;
  free_t         free_now;
  logic [PW:0]   occ_inc;
  free_t         take_raw;
  limit_t        lim_cap;
  free_t         take_cap;
  limit_t        take_n;
  logic          req_acc;

  wsd_ring #(.AW(AW)) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (bottom[AW-1:0]),
    .wr_data (task_handle),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign occ      = bottom - top;
  assign bot_dec  = bottom - PW'(1);
  assign full     = occ[AW];
  assign empty    = (occ == '0);
  assign free_now = FREE_W'(DEPTH) - FREE_W'(occ);
  assign occ_inc  = {1'b0, occ} + (PW+1)'(1);

  // Pop-half takes at least one handle; steal-half rounds up. Both are then
  // capped by the request's limit, which is itself capped at MAX_BATCH.
  always_comb begin
    if (kind == KIND_HALF) begin
      take_raw = FREE_W'(occ >> 1);
      if (take_raw == '0) begin
        take_raw = FREE_W'(1);
      end
    end else begin
      take_raw = FREE_W'(occ_inc >> 1);
    end
    lim_cap  = (batch_limit > MAX_BATCH) ? MAX_BATCH : batch_limit;
    take_cap = (take_raw < FREE_W'(lim_cap)) ? take_raw : FREE_W'(lim_cap);
    take_n   = take_cap[LIMIT_W-1:0];
  end

  // The result register takes a new result when it is empty or being drained.
  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && slot_free;
  assign req_acc   = req_valid && req_ready;

  // Only one request is in flight, and a push writes only from the idle state
  // while reads of a request come after it, so the ring never sees a write and
  // a read of the same entry in one cycle.
  always_comb begin
    state_next  = state;
    bottom_next = bottom;
    top_next    = top;
    remain_next = remain;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = top[AW-1:0];
    load        = 1'b0;
    ld_handle   = '0;
    ld_valid    = 1'b0;
    ld_last     = 1'b1;
    ld_status   = ST_OK;
    ld_free     = free_now;

    case (state)
      S_IDLE: begin
        if (req_acc) begin
          if (kind == KIND_PUSH) begin
            load = 1'b1;
            if (full) begin
              ld_status = ST_FULL;
            end else begin
              wr_en       = 1'b1;
              bottom_next = bottom + PW'(1);
              ld_free     = free_now - FREE_W'(1);
            end
          end else if (empty) begin
            load      = 1'b1;
            ld_status = ST_EMPTY;
          end else if (kind == KIND_POP) begin
            // Read the newest handle; its result follows once the data is back.
            rd_en       = 1'b1;
            rd_addr     = bot_dec[AW-1:0];
            bottom_next = bot_dec;
            state_next  = S_POP;
          end else if (take_n == '0) begin
            // A zero limit on a non-empty deque reports success, takes nothing.
            load = 1'b1;
          end else begin
            rd_en       = 1'b1;
            top_next    = top + PW'(1);
            remain_next = take_n;
            state_next  = S_BATCH;
          end
        end
      end

      S_POP: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_handle  = rd_data;
          ld_valid   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_BATCH: begin
        // Top already moved past the handle in rd_data, so free_now is the
        // count after this handle. The next read goes out with this result.
        if (slot_free) begin
          load      = 1'b1;
          ld_handle = rd_data;
          ld_valid  = 1'b1;
          ld_last   = (remain == LIMIT_W'(1));
          if (remain == LIMIT_W'(1)) begin
            state_next = S_IDLE;
          end else begin
            rd_en       = 1'b1;
            top_next    = top + PW'(1);
            remain_next = remain - LIMIT_W'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bottom    <= '0;
      top       <= '0;
      remain    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      bottom <= bottom_next;
      top    <= top_next;
      remain <= remain_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is only looked at with rsp_valid.
  always_ff @(posedge clk) begin
    if (load) begin
      out_handle   <= ld_handle;
      handle_valid <= ld_valid;
      last         <= ld_last;
      status       <= ld_status;
      free_slots   <= ld_free;
    end
  end

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the work-stealing task deque.
// Depends on wsd_pkg (kinds, status codes, field types) and the work_stealing_deque RTL.
// Drives requests at the falling edge and scores every result against a local deque model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam int DEPTH           = 64;
  localparam int IDX_W           = 7;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int RANDOM_REQUESTS = 126;
  localparam int PRINT_CAP       = 200;

  // One result as the block should present it.
  typedef struct {
    handle_t handle;
    logic    handle_valid;
    logic    last;
    status_t status;
    free_t   free_slots;
  } deque_result_t;

  logic    clk;
  logic    rst;
  logic    req_valid;
  logic    req_ready;
  kind_t   req_kind;
  handle_t task_handle;
  limit_t  batch_limit;
  logic    rsp_valid;
  logic    rsp_ready;
  handle_t out_handle;
  logic    handle_valid;
  logic    last;
  logic [1:0] status;
  free_t   free_slots;

  work_stealing_deque #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .kind         (req_kind),
    .task_handle  (task_handle),
    .batch_limit  (batch_limit),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .out_handle   (out_handle),
    .handle_valid (handle_valid),
    .last         (last),
    .status       (status),
    .free_slots   (free_slots)
  );

  // Local copy of the deque: ring contents and the two wrapping indices.
  // The indices count modulo twice the depth so that full and empty differ.
  handle_t          task_ring [DEPTH];
  logic [IDX_W-1:0] bottom_idx = '0;
  logic [IDX_W-1:0] top_idx    = '0;

  // Results still owed by the block, oldest first.
  deque_result_t pending_results[$];

  // Knobs shared between the test tasks, the request sender and the result-side process.
  bit sender_gaps_on = 1'b1;
  bit rsp_stalls_on  = 1'b1;
  bit rsp_hold_req   = 1'b0;

  int fail_count     = 0;
  int results_seen   = 0;
  int kind_count[4]  = '{default: 0};
  int refused_pushes = 0;
  int empty_takes    = 0;
  int reached_full   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or withholds results.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("work_stealing_deque verification failed");
    $finish;
  end

  // Idle lengths: mostly none or short, occasionally a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [IDX_W-1:0] occupancy();
    return bottom_idx - top_idx;
  endfunction

  // Builds a result; free slots are taken from the state as it stands now.
  function automatic deque_result_t make_result(handle_t h, logic hv, logic lst,
                                                status_t st);
    deque_result_t r;
    r.handle       = h;
    r.handle_valid = hv;
    r.last         = lst;
    r.status       = st;
    r.free_slots   = free_t'(DEPTH) - free_t'(occupancy());
    return r;
  endfunction

  // Applies one accepted request to the local deque and queues the results it
  // must produce, in order.
  task automatic predict_request(input kind_t k, input handle_t h, input limit_t lim);
    int size;
    int take;
    int cap;
    size = int'(occupancy());
    kind_count[k]++;
    if (k == KIND_PUSH) begin
      if (size >= DEPTH) begin
        refused_pushes++;
        pending_results.push_back(make_result('0, 1'b0, 1'b1, ST_FULL));
      end else begin
        task_ring[bottom_idx[IDX_W-2:0]] = h;
        bottom_idx = bottom_idx + 1'b1;
        if (int'(occupancy()) == DEPTH) reached_full++;
        pending_results.push_back(make_result('0, 1'b0, 1'b1, ST_OK));
      end
    end else if (size == 0) begin
      empty_takes++;
      pending_results.push_back(make_result('0, 1'b0, 1'b1, ST_EMPTY));
    end else if (k == KIND_POP) begin
      // The owner takes back its newest task.
      bottom_idx = bottom_idx - 1'b1;
      pending_results.push_back(make_result(task_ring[bottom_idx[IDX_W-2:0]], 1'b1,
                                            1'b1, ST_OK));
    end else begin
      // Pop-half rounds down but always takes one; steal-half rounds up.
      if (k == KIND_HALF) take = (size / 2 == 0) ? 1 : size / 2;
      else                take = (size + 1) / 2;
      cap = (int'(lim) > int'(MAX_BATCH)) ? int'(MAX_BATCH) : int'(lim);
      if (take > cap) take = cap;
      if (take == 0) begin
        pending_results.push_back(make_result('0, 1'b0, 1'b1, ST_OK));
      end else begin
        for (int i = 0; i < take; i++) begin
          h = task_ring[top_idx[IDX_W-2:0]];
          top_idx = top_idx + 1'b1;
          pending_results.push_back(make_result(h, 1'b1, (i + 1 == take), ST_OK));
        end
      end
    end
  endtask

  // Offers one request and holds it until the block takes it. The valid line
  // is left high when the next request follows at once, so it never drops and
  // rises within the same step.
  task automatic send_request(input kind_t k, input handle_t h, input limit_t lim);
    int gap;
    @(negedge clk);
    req_kind    <= k;
    task_handle <= h;
    batch_limit <= lim;
    req_valid   <= 1'b1;
    do @(posedge clk); while (!req_ready);
    predict_request(k, h, lim);
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every owed result has been delivered, with
  // a few spare cycles for anything the block might still emit.
  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Result side: random stalls, or one long hold-off when a test asks for it.
  // The hold-off is counted here so the sender keeps offering meanwhile.
  initial begin
    int stall;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_req) begin
        rsp_ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(negedge clk);
        rsp_hold_req = 1'b0;
        rsp_ready <= 1'b1;
      end else if (!rsp_stalls_on || $urandom_range(0, 3) != 0) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b0;
        stall = pick_gap();
        repeat (stall) @(negedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Scores each delivered result against the oldest owed one.
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= PRINT_CAP)
          $display("%0t: unexpected result, expected none, actual handle %0h status %0d",
                   $time, out_handle, status);
      end else begin
        want = pending_results.pop_front();
        check_field("out_handle",   want.handle,               out_handle);
        check_field("handle_valid", 32'(want.handle_valid),    32'(handle_valid));
        check_field("last",         32'(want.last),            32'(last));
        check_field("status",       32'(want.status),          32'(status));
        check_field("free_slots",   32'(want.free_slots),      32'(free_slots));
      end
    end
  end

  // Every take on a freshly reset deque must report empty, whatever the limit.
  task automatic test_empty_takes();
    send_request(KIND_POP,   32'h0000_0000, 7'd0);
    send_request(KIND_HALF,  32'hFFFF_FFFF, 7'd5);
    send_request(KIND_STEAL, 32'h1234_5678, 7'd0);
    send_request(KIND_STEAL, 32'h8765_4321, 7'd127);
    wait_idle();
  endtask

  // Extreme handles through push and pop, plus a zero limit on a non-empty
  // deque, which must answer with no handle and take nothing.
  task automatic test_push_pop_extremes();
    send_request(KIND_PUSH,  32'h0000_0000, 7'd0);
    send_request(KIND_PUSH,  32'hFFFF_FFFF, 7'd127);
    send_request(KIND_PUSH,  32'hA5A5_5A5A, 7'd64);
    send_request(KIND_POP,   32'h0,         7'd0);
    send_request(KIND_HALF,  32'h0,         7'd0);
    send_request(KIND_STEAL, 32'h0,         7'd0);
    send_request(KIND_POP,   32'h0,         7'd0);
    send_request(KIND_HALF,  32'h0,         7'd1);
    send_request(KIND_POP,   32'h0,         7'd0);
    wait_idle();
  endtask

  // Rounding of the two batch takes, a limit above the cap, and a limit that
  // cuts the batch short.
  task automatic test_batch_shapes();
    for (int i = 1; i <= 5; i++) send_request(KIND_PUSH, handle_t'(32'h1000_0000 + i), 7'd0);
    send_request(KIND_HALF,  32'h0, 7'd64);
    send_request(KIND_STEAL, 32'h0, 7'd127);
    send_request(KIND_HALF,  32'h0, 7'd3);
    for (int i = 1; i <= 3; i++) send_request(KIND_PUSH, handle_t'(32'h2000_0000 + i), 7'd0);
    send_request(KIND_STEAL, 32'h0, 7'd1);
    send_request(KIND_POP,   32'h0, 7'd0);
    wait_idle();
  endtask

  // The result side holds off for a long stretch while pushes keep coming, so
  // the block backs up; the pushes run past full to get refusals.
  task automatic test_fill_under_backpressure();
    int to_send;
    sender_gaps_on = 1'b0;
    rsp_hold_req   = 1'b1;
    to_send = DEPTH - int'(occupancy()) + 3;
    for (int i = 0; i < to_send; i++) send_request(KIND_PUSH, handle_t'($urandom()), 7'd0);
    sender_gaps_on = 1'b1;
    wait_idle();
  endtask

  // Largest batches come from a full deque.
  task automatic test_full_batches();
    send_request(KIND_STEAL, 32'h0, 7'd64);
    send_request(KIND_HALF,  32'h0, 7'd100);
    send_request(KIND_STEAL, 32'h0, 7'd7);
    send_request(KIND_POP,   32'h0, 7'd0);
    send_request(KIND_HALF,  32'h0, 7'd0);
    wait_idle();
  endtask

  // Mixed traffic. The push share follows the occupancy, higher when the deque
  // is nearly empty and lower when it is nearly full. Quiet stretches with no
  // idling on either side alternate with noisy ones.
  task automatic test_random_traffic();
    int     roll;
    int     push_pct;
    int     size;
    kind_t  k;
    limit_t lim;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 25) begin
        sender_gaps_on = 1'b0;
        rsp_stalls_on  = 1'b0;
      end else if (n % 50 == 0) begin
        sender_gaps_on = 1'b1;
        rsp_stalls_on  = 1'b1;
      end
      size = int'(occupancy());
      push_pct = (size < 8) ? 70 : (size > 56) ? 25 : 50;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        k = KIND_PUSH;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 35)      k = KIND_POP;
        else if (roll < 65) k = KIND_HALF;
        else                k = KIND_STEAL;
      end
      roll = $urandom_range(0, 9);
      if (roll == 0)      lim = '0;
      else if (roll == 1) lim = limit_t'($urandom_range(64, 127));
      else                lim = limit_t'($urandom_range(1, 40));
      send_request(k, handle_t'($urandom()), lim);
    end
    sender_gaps_on = 1'b1;
    rsp_stalls_on  = 1'b1;
    wait_idle();
  endtask

  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    req_kind    = KIND_PUSH;
    task_handle = '0;
    batch_limit = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_takes();
    test_push_pop_extremes();
    test_batch_shapes();
    test_fill_under_backpressure();
    test_full_batches();
    test_random_traffic();

    // Everything owed has arrived; leave room for any stray result.
    repeat (10) @(posedge clk);

    $display("Covered %0d requests: %0d push, %0d pop, %0d pop-half, %0d steal-half.",
             kind_count[KIND_PUSH] + kind_count[KIND_POP] + kind_count[KIND_HALF]
             + kind_count[KIND_STEAL], kind_count[KIND_PUSH], kind_count[KIND_POP],
             kind_count[KIND_HALF], kind_count[KIND_STEAL]);
    $display("Scored %0d results; %0d refused pushes, %0d empty takes, full reached %0d times.",
             results_seen, refused_pushes, empty_takes, reached_full);
    if (fail_count == 0) begin
      $display("work_stealing_deque verification clean");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("work_stealing_deque verification failed");
    end
    $finish;
  end

endmodule
